>>> design/sparse_rips_edge_filter_unit_assert.svh
// Assertion macros for the sparse Rips edge filter unit.
`ifndef SPARSE_RIPS_EDGE_FILTER_UNIT_ASSERT_SVH
`define SPARSE_RIPS_EDGE_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define SRIPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("srips assertion failed");
// Check cons in the cycle after ante.
`define SRIPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("srips assertion failed");
`else
`define SRIPS_ASSERT_NOW(label, ante, cons)
`define SRIPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> design/srips_pkg.sv
// Shared constants and codes of the sparse Rips edge filter.
`timescale 1ns / 1ps
package srips_pkg;
   localparam int NUM_POINTS_DEF = 1024;
   localparam int NUM_DIMS_DEF   = 8;
   localparam int NUM_LEVELS_DEF = 32;

   localparam int COORD_W = 24;
   localparam int RADIUS_W = 24;
   localparam int SCALE_W = 24;
   localparam int DEATH_W = 32;
   localparam int PRODUCT_W = RADIUS_W + SCALE_W;
   localparam int SCALE_FRAC = 16;
   localparam int LENGTH_W = 32;

   localparam logic signed [7:0] ROOT_LEVEL_RST = 8'sd0;
   localparam logic [SCALE_W-1:0] DEATH_SCALE_RST = 24'd589824;
   localparam logic [3:0] DIMS_IN_USE_RST = 4'd8;

   typedef enum logic [1:0] {
      CSR_ROOT_LEVEL  = 2'd0,
      CSR_DEATH_SCALE = 2'd1,
      CSR_DIMS_IN_USE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FUNC_WR_COORD  = 2'd0,
      FUNC_WR_RADIUS = 2'd1,
      FUNC_WR_LEVEL  = 2'd2,
      FUNC_EVAL_PAIR = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ADDED     = 2'd1,
      STATUS_NOT_ADDED = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;
endpackage

>>> design/srips_div3.sv
// Divide by three through a reciprocal multiply.
`timescale 1ns / 1ps
module srips_div3 (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [srips_pkg::DEATH_W-1:0] dividend,
   output logic                         done,
   output logic [srips_pkg::DEATH_W-1:0] quotient
);
   import srips_pkg::*;

   // Two to the 33rd over three, rounded up; exact floor for every 32-bit dividend
   localparam logic [DEATH_W-1:0] RECIP_3 = 32'hAAAA_AAAB;
   localparam int RECIP_SHIFT = DEATH_W + 1;
   localparam int PROD_W = 2 * DEATH_W;

   logic [PROD_W-1:0] prod_ff;
   logic              done_ff;

   // Flag the quotient ready in the cycle after the first start; only reset clears the flag
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (start) begin
         done_ff <= 1'b1;
      end
   end

   // Form the scaled product
   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= PROD_W'(dividend) * PROD_W'(RECIP_3);
      end
   end

   assign done     = done_ff;
   assign quotient = DEATH_W'(prod_ff[PROD_W-1:RECIP_SHIFT]);
endmodule

>>> design/srips_isqrt.sv
// Iterative integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module srips_isqrt #(
   parameter int SUM_W = 54
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_W-1:0]     radicand,
   output logic                 done,
   output logic [SUM_W/2-1:0]   root
);
   localparam int RT_W = SUM_W / 2;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [SUM_W-1:0] x_ff;
   logic [RT_W:0]    rem_ff;
   logic [RT_W-1:0]  root_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [RT_W+2:0] rem_cat;
   logic [RT_W+2:0] trial;
   logic            ge;

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      rem_cat = {rem_ff, x_ff[SUM_W-1 -: 2]};
      trial   = (RT_W+3)'({root_ff, 2'b01});
      ge      = (rem_cat >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         x_ff    <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CNT_W'(RT_W);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[SUM_W-3:0], 2'b00};
         rem_ff  <= ge ? (RT_W+1)'(rem_cat - trial) : (RT_W+1)'(rem_cat);
         root_ff <= {root_ff[RT_W-2:0], ge};
         cnt_ff  <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

>>> design/sparse_rips_edge_filter_unit.sv
// Sparse Rips edge filter: point stores, death times and the pair edge rule.
`timescale 1ns / 1ps
`include "sparse_rips_edge_filter_unit_assert.svh"
// One transaction at a time; each gives exactly one response. A coordinate or radius
// write goes straight to its response; a level write first reads the radius, multiplies
// it by the death scale and writes the death time. A pair query reads min(dims_in_use,
// NUM_DIMS) coordinates of each point: the coordinate memory has one read port, so both
// points come one word a cycle, and the square root then resolves one bit per cycle.
// A waiting response sits in the output register; the next transaction is taken
// meanwhile. Stores hold undefined data until written; there is no clearing pass.
module sparse_rips_edge_filter_unit #(
   parameter int NUM_POINTS = srips_pkg::NUM_POINTS_DEF,
   parameter int NUM_DIMS   = srips_pkg::NUM_DIMS_DEF,
   parameter int NUM_LEVELS = srips_pkg::NUM_LEVELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [9:0]  req_point_a,
   input  logic [9:0]  req_point_b,
   input  logic [2:0]  req_dim_index,
   input  logic [4:0]  req_level_slot,
   input  logic signed [23:0] req_coord_value,
   input  logic [23:0] req_radius_value,
   input  logic signed [7:0]  req_point_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_edge_from,
   output logic [9:0]  rsp_edge_to,
   output logic [31:0] rsp_edge_length,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data
);
   import srips_pkg::*;

   localparam int PAW = $clog2(NUM_POINTS);
   localparam int CAW = $clog2(NUM_POINTS * NUM_DIMS);
   localparam int LAW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int NDW = $clog2(NUM_DIMS + 1);
   localparam int MAG_W = COORD_W + 1;
   localparam int SQ_W = 2 * MAG_W;
   localparam int SUM_RAW = SQ_W + $clog2(NUM_DIMS);
   localparam int SUM_W = SUM_RAW + (SUM_RAW % 2);
   localparam int RT_W = SUM_W / 2;
   localparam int PH_W = $clog2(2 * NUM_DIMS + 5);
   localparam int CMP_W = (RT_W + 4 > DEATH_W + 2) ? RT_W + 4 : DEATH_W + 2;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_LVL_MUL = 6'b000010,
      ST_LVL_WR  = 6'b000100,
      ST_Q_RUN   = 6'b001000,
      ST_Q_ROOT  = 6'b010000,
      ST_RESP    = 6'b100000
   } state_type;

   // Configuration registers
   logic signed [7:0]  root_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [3:0]         dims_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff  <= ROOT_LEVEL_RST;
         scale_ff <= DEATH_SCALE_RST;
         dims_ff  <= DIMS_IN_USE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROOT_LEVEL:  root_ff  <= csr_write_data[7:0];
            CSR_DEATH_SCALE: scale_ff <= csr_write_data;
            CSR_DIMS_IN_USE: dims_ff  <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   // Control and payload registers
   state_type state_ff, state_in;
   logic [PH_W-1:0]     ph_ff, ph_in;
   logic [9:0]          pa_ff, pa_in;
   logic [9:0]          pb_ff, pb_in;
   logic                lvl_pa_ok_ff, lvl_pa_ok_in;
   logic [1:0]          res_status_ff, res_status_in;
   logic [9:0]          res_from_ff, res_from_in;
   logic [9:0]          res_to_ff, res_to_in;
   logic [LENGTH_W-1:0] res_len_ff, res_len_in;
   logic [DEATH_W-1:0]  tp_ff, tp_in;
   logic [DEATH_W-1:0]  tq_ff, tq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic [9:0]          rsp_from_ff;
   logic [9:0]          rsp_to_ff;
   logic [LENGTH_W-1:0] rsp_len_ff;

   // Memories and their registered read data
   logic [COORD_W-1:0]  coord_mem [NUM_POINTS*NUM_DIMS];
   logic [DEATH_W-1:0]  death_mem [NUM_POINTS];
   logic [RADIUS_W-1:0] rad_mem [NUM_LEVELS];
   logic signed [COORD_W-1:0] coord_rd_ff;
   logic [DEATH_W-1:0]  death_rd_ff;
   logic [RADIUS_W-1:0] rad_rd_ff;
   logic [PRODUCT_W-1:0] prod_ff;

   // Distance datapath
   logic signed [COORD_W-1:0] a_ff;
   logic                rd_vld_ff, rd_vld_in;
   logic                rd_isb_ff;
   logic [MAG_W-1:0]    mag_ff;
   logic                mag_vld_ff;
   logic [SQ_W-1:0]     sq_ff;
   logic                sq_vld_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;

   logic accept;
   logic pa_ok, pb_ok, dim_ok, slot_ok, lvl_ok;
   logic signed [8:0] lvl_rel;
   logic [CAW-1:0] cw_addr, cq_addr;
   logic           cw_en, rw_en, dw_en;
   logic [PAW-1:0] dr_addr;
   logic [9:0]     q_pt;
   logic [NDW-1:0] nd;
   logic [PH_W-1:0] ph_end;
   logic           units_start;
   logic           root_done, div_done;
   logic [RT_W-1:0] root;
   logic [DEATH_W-1:0] tp_div3;
   logic signed [MAG_W-1:0] diff;
   logic [CMP_W-1:0] d_x, d3_x, d6_x, tp_x, tq_x;
   logic             rsp_load;

   assign accept  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Decode range checks of the incoming transaction
   always_comb begin
      pa_ok   = (32'(req_point_a) < 32'(NUM_POINTS));
      pb_ok   = (32'(req_point_b) < 32'(NUM_POINTS));
      dim_ok  = (32'(req_dim_index) < 32'(NUM_DIMS));
      slot_ok = (32'(req_level_slot) < 32'(NUM_LEVELS));
      lvl_rel = 9'(req_point_level) - 9'(root_ff);
      lvl_ok  = !lvl_rel[8] && (32'(lvl_rel[7:0]) < 32'(NUM_LEVELS));
      nd      = (32'(dims_ff) > 32'(NUM_DIMS)) ? NDW'(NUM_DIMS) : NDW'(dims_ff);
      ph_end  = PH_W'({nd, 1'b0}) + PH_W'(4);
   end

   // Memory address and write strobes
   always_comb begin
      cw_en   = accept && (req_func == FUNC_WR_COORD) && pa_ok && dim_ok;
      rw_en   = accept && (req_func == FUNC_WR_RADIUS) && slot_ok;
      dw_en   = (state_ff == ST_LVL_WR) && lvl_pa_ok_ff;
      cw_addr = CAW'(32'(req_point_a) * NUM_DIMS + 32'(req_dim_index));
      q_pt    = ph_ff[0] ? pb_ff : pa_ff;
      cq_addr = CAW'(32'(q_pt) * NUM_DIMS + 32'(ph_ff[PH_W-1:1]));
      dr_addr = (ph_ff == '0) ? PAW'(pa_ff) : PAW'(pb_ff);
   end

   always_ff @(posedge clock) begin
      if (cw_en) begin
         coord_mem[cw_addr] <= req_coord_value;
      end
      coord_rd_ff <= coord_mem[cq_addr];
   end

   always_ff @(posedge clock) begin
      if (dw_en) begin
         death_mem[PAW'(pa_ff)] <= prod_ff[PRODUCT_W-1 -: DEATH_W];
      end
      death_rd_ff <= death_mem[dr_addr];
   end

   always_ff @(posedge clock) begin
      if (rw_en) begin
         rad_mem[LAW'(req_level_slot)] <= req_radius_value;
      end
      rad_rd_ff <= rad_mem[LAW'(lvl_rel[7:0])];
   end

   // Scale the radius into a death time
   always_ff @(posedge clock) begin
      prod_ff <= PRODUCT_W'(rad_rd_ff) * PRODUCT_W'(scale_ff);
   end

   // Squared-difference pipeline: fetch, difference, square, accumulate
   assign diff = MAG_W'(a_ff) - MAG_W'(coord_rd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mag_vld_ff <= 1'b0;
         sq_vld_ff  <= 1'b0;
      end else begin
         rd_vld_ff  <= rd_vld_in;
         mag_vld_ff <= rd_vld_ff && rd_isb_ff;
         sq_vld_ff  <= mag_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_isb_ff <= ph_ff[0];
      if (rd_vld_ff && !rd_isb_ff) begin
         a_ff <= coord_rd_ff;
      end
      mag_ff <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      sq_ff  <= SQ_W'(mag_ff) * SQ_W'(mag_ff);
      sum_ff <= sum_in;
   end

   srips_isqrt #(
      .SUM_W(SUM_W)
   ) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (units_start),
      .radicand(sum_ff),
      .done    (root_done),
      .root    (root)
   );

   srips_div3 u_div3 (
      .clock   (clock),
      .reset   (reset),
      .start   (units_start),
      .dividend(tp_ff),
      .done    (div_done),
      .quotient(tp_div3)
   );

   // Edge rule operands
   always_comb begin
      d_x  = CMP_W'(root);
      d3_x = (d_x << 1) + d_x;
      d6_x = d3_x << 1;
      tp_x = CMP_W'(tp_ff);
      tq_x = CMP_W'(tq_ff);
   end

   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ph_in         = ph_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      lvl_pa_ok_in  = lvl_pa_ok_ff;
      res_status_in = res_status_ff;
      res_from_in   = res_from_ff;
      res_to_in     = res_to_ff;
      res_len_in    = res_len_ff;
      tp_in         = tp_ff;
      tq_in         = tq_ff;
      rd_vld_in     = 1'b0;
      sum_in        = sq_vld_ff ? sum_ff + SUM_W'(sq_ff) : sum_ff;
      units_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pa_in         = req_point_a;
               pb_in         = req_point_b;
               res_from_in   = '0;
               res_to_in     = '0;
               res_len_in    = '0;
               res_status_in = STATUS_OK;
               ph_in         = '0;
               sum_in        = '0;
               state_in      = ST_RESP;
               unique case (req_func)
                  FUNC_WR_COORD: ;
                  FUNC_WR_RADIUS: begin
                     if (!slot_ok) begin
                        res_status_in = STATUS_RANGE;
                     end
                  end
                  FUNC_WR_LEVEL: begin
                     if (!lvl_ok) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        lvl_pa_ok_in = pa_ok;
                        state_in     = ST_LVL_MUL;
                     end
                  end
                  FUNC_EVAL_PAIR: begin
                     res_from_in   = req_point_a;
                     res_to_in     = req_point_b;
                     res_status_in = STATUS_NOT_ADDED;
                     if (pa_ok && pb_ok) begin
                        state_in = ST_Q_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LVL_MUL: begin
            state_in = ST_LVL_WR;
         end
         ST_LVL_WR: begin
            state_in = ST_RESP;
         end
         ST_Q_RUN: begin
            rd_vld_in = (ph_ff < PH_W'({nd, 1'b0}));
            ph_in     = ph_ff + PH_W'(1);
            if (ph_ff == PH_W'(1)) begin
               tp_in = death_rd_ff;
            end
            // Order the two death times once both are in
            if (ph_ff == PH_W'(2)) begin
               tp_in = (death_rd_ff < tp_ff) ? death_rd_ff : tp_ff;
               tq_in = (death_rd_ff < tp_ff) ? tp_ff : death_rd_ff;
            end
            if (ph_ff == ph_end) begin
               units_start = 1'b1;
               state_in    = ST_Q_ROOT;
            end
         end
         ST_Q_ROOT: begin
            if (root_done && div_done) begin
               state_in = ST_RESP;
               if (d3_x < tp_x) begin
                  res_status_in = STATUS_ADDED;
                  res_len_in    = LENGTH_W'(d_x);
               end else if ((d3_x <= (tp_x << 1)) && (d6_x <= tp_x + tq_x)) begin
                  res_status_in = STATUS_ADDED;
                  res_len_in    = LENGTH_W'((d_x << 1) - CMP_W'(tp_div3));
               end
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      lvl_pa_ok_ff  <= lvl_pa_ok_in;
      res_status_ff <= res_status_in;
      res_from_ff   <= res_from_in;
      res_to_ff     <= res_to_in;
      res_len_ff    <= res_len_in;
      tp_ff         <= tp_in;
      tq_ff         <= tq_in;
   end

   // Output register: hold the response until it is taken
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_from_ff   <= res_from_ff;
         rsp_to_ff     <= res_to_ff;
         rsp_len_ff    <= res_len_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_edge_from   = rsp_from_ff;
   assign rsp_edge_to     = rsp_to_ff;
   assign rsp_edge_length = rsp_len_ff;

   `SRIPS_ASSERT_NEXT(a_resp_loads, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE))
   `SRIPS_ASSERT_NOW(a_pipe_drained, state_ff != ST_Q_RUN, !rd_vld_ff && !mag_vld_ff && !sq_vld_ff)
   `SRIPS_ASSERT_NOW(a_len_zero, rsp_valid_ff && (rsp_status_ff != STATUS_ADDED), rsp_len_ff == '0)
endmodule
